@@ hdl/integer_to_csd_digits_core_assert.svh @@
// Assertion macros for the CSD digit converter.
// Each macro takes a label, the clock, the active-low reset and the checked expression.
`ifndef INTEGER_TO_CSD_DIGITS_CORE_ASSERT_SVH
`define INTEGER_TO_CSD_DIGITS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CSD_ASSERT_PROP(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("CSD converter: assertion failed");
`define CSD_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) \
		else $error("CSD converter: forbidden condition seen");
`else
`define CSD_ASSERT_PROP(lbl, clk_sig, rst_n_sig, prop)
`define CSD_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr)
`endif
`endif

@@ hdl/i2csd_pkg.sv @@
`default_nettype none
package i2csd_pkg;

	// Fixed widths of the result fields.
	localparam int PLUS_W  = 16;
	localparam int MINUS_W = 16;
	localparam int COUNT_W = 5;

	// Control flags that travel along the cell chain with each request.
	typedef struct packed {
		logic valid;
		logic found;
	} ctl_t;

endpackage
`default_nettype wire

@@ hdl/i2csd_cell.sv @@
`default_nettype none
// One digit position of the converter: decides the digit of weight 2^POS and
// updates the remainder, then hands everything on to the next cell.
module i2csd_cell #(
	parameter int WIDTH = 16,
	parameter int POS   = 0
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire i2csd_pkg::ctl_t          prev_ctl,
	input  wire logic signed [WIDTH:0]    prev_rem,
	input  wire logic [WIDTH+1:0]         prev_t,
	input  wire logic [WIDTH-1:0]         prev_plus,
	input  wire logic [WIDTH-1:0]         prev_minus,
	input  wire logic [$clog2(WIDTH+1)-1:0] prev_cnt,
	output i2csd_pkg::ctl_t               next_ctl,
	output logic signed [WIDTH:0]         next_rem,
	output logic [WIDTH+1:0]              next_t,
	output logic [WIDTH-1:0]              next_plus,
	output logic [WIDTH-1:0]              next_minus,
	output logic [$clog2(WIDTH+1)-1:0]    next_cnt
);

	localparam int REM_W = WIDTH + 1;
	localparam int D_W   = WIDTH + 3;
	localparam int T_W   = WIDTH + 2;
	localparam int CW    = $clog2(WIDTH + 1);

	localparam logic signed [D_W-1:0]   THR  = D_W'(64'sd1 <<< (POS + 1));
	localparam logic signed [D_W-1:0]   NTHR = -THR;
	localparam logic signed [REM_W-1:0] WGT  = REM_W'(64'sd1 <<< POS);
	localparam logic [T_W-1:0]          TLIM = T_W'(64'd1 << (POS + 1));

	logic signed [D_W-1:0]   rem_x;
	logic signed [D_W-1:0]   d3;
	logic                    pos_dig;
	logic                    neg_dig;
	logic                    hit;
	logic signed [REM_W-1:0] rem_n;
	logic [WIDTH-1:0]        plus_n;
	logic [WIDTH-1:0]        minus_n;

	i2csd_pkg::ctl_t        ctl_q;
	logic signed [REM_W-1:0] rem_q;
	logic [T_W-1:0]         t_q;
	logic [WIDTH-1:0]       plus_q;
	logic [WIDTH-1:0]       minus_q;
	logic [CW-1:0]          cnt_q;

	always_comb begin
		rem_x   = D_W'(prev_rem);
		d3      = (rem_x <<< 1) + rem_x;
		pos_dig = d3 > THR;
		neg_dig = d3 < NTHR;
		// The highest position whose threshold fits under three times the magnitude
		// fixes the digit count.
		hit     = !prev_ctl.found && (prev_t >= TLIM);
		rem_n   = prev_rem;
		if (pos_dig) begin
			rem_n = prev_rem - WGT;
		end else if (neg_dig) begin
			rem_n = prev_rem + WGT;
		end
		plus_n       = prev_plus;
		plus_n[POS]  = pos_dig;
		minus_n      = prev_minus;
		minus_n[POS] = neg_dig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid <= prev_ctl.valid;
			ctl_q.found <= prev_ctl.found | hit;
		end
	end

	always_ff @(posedge clk) begin
		rem_q   <= rem_n;
		t_q     <= prev_t;
		plus_q  <= plus_n;
		minus_q <= minus_n;
		cnt_q   <= hit ? CW'(POS + 1) : prev_cnt;
	end

	assign next_ctl   = ctl_q;
	assign next_rem   = rem_q;
	assign next_t     = t_q;
	assign next_plus  = plus_q;
	assign next_minus = minus_q;
	assign next_cnt   = cnt_q;

endmodule
`default_nettype wire

@@ hdl/integer_to_csd_digits_core.sv @@
`default_nettype none
// Channel  | Handshake     | Payload
// ---------+---------------+-----------------------------------------
// request  | start / busy  | value
// result   | done (strobe) | plus_mask, minus_mask, digit_count
//
// A request is taken at every rising edge with start high and busy low; busy
// is always low, so a new request may follow in every cycle.
// Each result passes through one input register, one cell per digit position
// in the chain, and the output register.
// The asynchronous reset clears the valid and found flags in every stage, so
// requests in flight are dropped. The receiver cannot stall the results.
`include "integer_to_csd_digits_core_assert.svh"
module integer_to_csd_digits_core #(
	parameter int WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [WIDTH-1:0]       value,
	output logic                               done,
	output logic [i2csd_pkg::PLUS_W-1:0]       plus_mask,
	output logic [i2csd_pkg::MINUS_W-1:0]      minus_mask,
	output logic [i2csd_pkg::COUNT_W-1:0]      digit_count
);

	localparam int REM_W = WIDTH + 1;
	localparam int T_W   = WIDTH + 2;
	localparam int CW    = $clog2(WIDTH + 1);

	// Links between the stages. Link 0 is the input register; link j feeds the cell
	// that decides digit position WIDTH-1-j, so the chain walks from the most
	// significant digit downwards, as the greedy rule needs.
	i2csd_pkg::ctl_t         ctl_l   [WIDTH+1];
	logic signed [REM_W-1:0] rem_l   [WIDTH+1];
	logic [T_W-1:0]          t_l     [WIDTH+1];
	logic [WIDTH-1:0]        plus_l  [WIDTH+1];
	logic [WIDTH-1:0]        minus_l [WIDTH+1];
	logic [CW-1:0]           cnt_l   [WIDTH+1];

	// Input register: the remainder starts as the value itself, and three times the
	// magnitude is kept for the digit count search in the cells.
	logic                    valid_s0;
	logic signed [REM_W-1:0] rem_s0;
	logic [T_W-1:0]          t_s0;
	logic [WIDTH-1:0]        mag;

	// The magnitude of the most negative value is 2^(WIDTH-1), which still fits in
	// WIDTH unsigned bits.
	assign mag = value[WIDTH-1] ? WIDTH'(-value) : WIDTH'(value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		rem_s0 <= REM_W'(value);
		t_s0   <= {2'b00, mag} + {1'b0, mag, 1'b0};
	end

	assign ctl_l[0]   = '{valid: valid_s0, found: 1'b0};
	assign rem_l[0]   = rem_s0;
	assign t_l[0]     = t_s0;
	assign plus_l[0]  = '0;
	assign minus_l[0] = '0;
	assign cnt_l[0]   = '0;

	for (genvar j = 0; j < WIDTH; j++) begin : g_cell
		i2csd_cell #(
			.WIDTH (WIDTH),
			.POS   (WIDTH - 1 - j)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_ctl   (ctl_l[j]),
			.prev_rem   (rem_l[j]),
			.prev_t     (t_l[j]),
			.prev_plus  (plus_l[j]),
			.prev_minus (minus_l[j]),
			.prev_cnt   (cnt_l[j]),
			.next_ctl   (ctl_l[j+1]),
			.next_rem   (rem_l[j+1]),
			.next_t     (t_l[j+1]),
			.next_plus  (plus_l[j+1]),
			.next_minus (minus_l[j+1]),
			.next_cnt   (cnt_l[j+1])
		);
	end

	// When no position reached the threshold the value is small enough for a
	// single digit, so the count defaults to one. The masks and the count are
	// zero-extended or truncated to the fixed result widths.
	logic [CW-1:0]                         cnt_fin;
	logic [WIDTH+i2csd_pkg::PLUS_W-1:0]    plus_ext;
	logic [WIDTH+i2csd_pkg::MINUS_W-1:0]   minus_ext;
	logic [CW+i2csd_pkg::COUNT_W-1:0]      cnt_ext;

	assign cnt_fin   = ctl_l[WIDTH].found ? cnt_l[WIDTH] : CW'(1);
	assign plus_ext  = {{i2csd_pkg::PLUS_W{1'b0}}, plus_l[WIDTH]};
	assign minus_ext = {{i2csd_pkg::MINUS_W{1'b0}}, minus_l[WIDTH]};
	assign cnt_ext   = {{i2csd_pkg::COUNT_W{1'b0}}, cnt_fin};

	logic                            done_q;
	logic [i2csd_pkg::PLUS_W-1:0]    plus_q;
	logic [i2csd_pkg::MINUS_W-1:0]   minus_q;
	logic [i2csd_pkg::COUNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_l[WIDTH].valid;
		end
	end

	always_ff @(posedge clk) begin
		plus_q  <= plus_ext[i2csd_pkg::PLUS_W-1:0];
		minus_q <= minus_ext[i2csd_pkg::MINUS_W-1:0];
		cnt_q   <= cnt_ext[i2csd_pkg::COUNT_W-1:0];
	end

	// The chain is fully pipelined, so requests are never refused.
	assign busy        = 1'b0;
	assign done        = done_q;
	assign plus_mask   = plus_q;
	assign minus_mask  = minus_q;
	assign digit_count = cnt_q;

	// Positions that carry a nonzero digit of either sign.
	logic [i2csd_pkg::PLUS_W-1:0] digit_nz;

	assign digit_nz = plus_mask | minus_mask;

	// Every request produces a result, and no result appears
	// without a request behind it.
	`CSD_ASSERT_PROP(a_latency, clk, arst_n, start && !busy |-> ##(WIDTH+2) done)
	`CSD_ASSERT_PROP(a_no_orphan, clk, arst_n, done |-> $past(start, WIDTH+2))
	// A position never carries both a plus and a minus digit.
	`CSD_ASSERT_NEVER(a_disjoint, clk, arst_n, done && ((plus_mask & minus_mask) != '0))
	// Canonical form: no two neighbouring digits are both nonzero.
	`CSD_ASSERT_NEVER(a_nonadjacent, clk, arst_n, done && (((digit_nz >> 1) & digit_nz) != '0))

endmodule
`default_nettype wire
